@@ sv/sfc_pkg.sv @@
package sfc_pkg;

  // Default plane count and fixed field widths
  localparam int NUM_PLANES_DEF = 6;
  localparam int FLAG_BITS      = 6;
  localparam int IDX_W          = 3;
  localparam int NORM_W         = 16;
  localparam int COORD_W        = 32;
  localparam int RADIUS_W       = 31;
  localparam int FRAC_SHIFT     = 14;
  localparam int PROD_W         = COORD_W + NORM_W;
  localparam int DIST_W         = PROD_W + 2;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // Stage enables and store write, shared by every lane
  typedef struct packed {
    logic load;
    logic en_a;
    logic en_b;
    logic en_c;
  } sfc_ctrl_t;

endpackage

@@ sv/sphere_frustum_cull_top.sv @@
// A test word passes the stages in order and leaves as one result word.
// Throughput: one word per cycle unless stalled, loads and tests alike; four register
//   stages (products, distance sum, radius compare, result) with per-stage valid bits.
// A load word updates its plane at acceptance and gives no result word.
// Reset (rst, synchronous, active high) clears all valid bits and every plane to zero.
module sphere_frustum_cull_top #(
  parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic                                 command,
  input  logic        [sfc_pkg::IDX_W-1:0]     plane_index,
  input  logic signed [sfc_pkg::NORM_W-1:0]    normal_x,
  input  logic signed [sfc_pkg::NORM_W-1:0]    normal_y,
  input  logic signed [sfc_pkg::NORM_W-1:0]    normal_z,
  input  logic signed [sfc_pkg::COORD_W-1:0]   plane_offset,
  input  logic signed [sfc_pkg::COORD_W-1:0]   center_x,
  input  logic signed [sfc_pkg::COORD_W-1:0]   center_y,
  input  logic signed [sfc_pkg::COORD_W-1:0]   center_z,
  input  logic        [sfc_pkg::RADIUS_W-1:0]  radius,
  input  logic        [sfc_pkg::FLAG_BITS-1:0] clip_flags,
  input  logic        [sfc_pkg::FLAG_BITS-1:0] clip_mask,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic                                 outside,
  output logic        [sfc_pkg::FLAG_BITS-1:0] flags_out
);
  import sfc_pkg::*;

  // Planes beyond the flag width are never examined
  localparam int NL = (NUM_PLANES < FLAG_BITS) ? NUM_PLANES : FLAG_BITS;

  sfc_ctrl_t ctrl;

  logic va, vb, vc;
  logic en_a, en_b, en_c, en_d;

  logic [RADIUS_W-1:0]  radius_a, radius_b;
  logic [FLAG_BITS-1:0] flags_a, flags_b, flags_c;
  logic [FLAG_BITS-1:0] sel_a, sel_b, sel_c;

  logic [NL-1:0]        over, under;
  logic [FLAG_BITS-1:0] over_w, under_w;
  logic                 outside_next;

  // Advance a stage when the one after it is empty or advancing
  assign en_d = !res_valid || !res_stall;
  assign en_c = !vc || en_d;
  assign en_b = !vb || en_c;
  assign en_a = !va || en_b;

  assign cmd_stall = !en_a;

  assign ctrl.load = cmd_valid && en_a && (command == CMD_LOAD);
  assign ctrl.en_a = en_a;
  assign ctrl.en_b = en_b;
  assign ctrl.en_c = en_c;

  // Valid bits travel with the words; a load leaves stage A empty
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en_a) va <= cmd_valid && (command == CMD_TEST);
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) res_valid <= vc;
    end
  end

  // Carry radius, flags and selection alongside the lanes
  always_ff @(posedge clk) begin
    if (en_a) begin
      radius_a <= radius;
      flags_a  <= clip_flags;
      sel_a    <= clip_flags & clip_mask;
    end
    if (en_b) begin
      radius_b <= radius_a;
      flags_b  <= flags_a;
      sel_b    <= sel_a;
    end
    if (en_c) begin
      flags_c  <= flags_b;
      sel_c    <= sel_b;
    end
  end

  // One lane per plane, side by side
  for (genvar p = 0; p < NL; p++) begin : g_lane
    sfc_lane #(
      .LANE_IDX(p)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .plane_index (plane_index),
      .normal_x    (normal_x),
      .normal_y    (normal_y),
      .normal_z    (normal_z),
      .plane_offset(plane_offset),
      .center_x    (center_x),
      .center_y    (center_y),
      .center_z    (center_z),
      .radius_b    (radius_b),
      .over        (over[p]),
      .under       (under[p])
    );
  end

  // Widen lane results to the flag width; missing planes never hit
  always_comb begin
    over_w  = '0;
    under_w = '0;
    for (int i = 0; i < NL; i++) begin
      over_w[i]  = over[i];
      under_w[i] = under[i];
    end
  end

  assign outside_next = |(over_w & sel_c);

  // Drop fully-inside planes, zero everything when outside
  always_ff @(posedge clk) begin
    if (en_d) begin
      outside   <= outside_next;
      flags_out <= outside_next ? '0 : (flags_c & ~(under_w & sel_c));
    end
  end

`ifndef SYNTHESIS
  a_outside_clears_flags: assert property (@(posedge clk) disable iff (rst)
    (res_valid && outside) |-> (flags_out == '0))
    else $error("outside result with nonzero flags");

  a_test_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && (command == CMD_TEST)) |=> va)
    else $error("accepted test word missing from stage A");

  a_stage_a_holds: assert property (@(posedge clk) disable iff (rst)
    (va && !en_b) |=> va)
    else $error("stalled stage A word lost");

  a_accept_behind_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall && !vc) |-> !cmd_stall)
    else $error("input stalled while pipeline has room");
`endif

endmodule

@@ sv/sfc_lane.sv @@
module sfc_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sfc_pkg::sfc_ctrl_t                   ctrl,
  input  logic        [sfc_pkg::IDX_W-1:0]     plane_index,
  input  logic signed [sfc_pkg::NORM_W-1:0]    normal_x,
  input  logic signed [sfc_pkg::NORM_W-1:0]    normal_y,
  input  logic signed [sfc_pkg::NORM_W-1:0]    normal_z,
  input  logic signed [sfc_pkg::COORD_W-1:0]   plane_offset,
  input  logic signed [sfc_pkg::COORD_W-1:0]   center_x,
  input  logic signed [sfc_pkg::COORD_W-1:0]   center_y,
  input  logic signed [sfc_pkg::COORD_W-1:0]   center_z,
  input  logic        [sfc_pkg::RADIUS_W-1:0]  radius_b,
  output logic                                 over,
  output logic                                 under
);
  import sfc_pkg::*;

  // Plane store for this slot
  logic signed [NORM_W-1:0]  nx;
  logic signed [NORM_W-1:0]  ny;
  logic signed [NORM_W-1:0]  nz;
  logic signed [COORD_W-1:0] off;

  // Stage A: products and offset snapshot
  logic signed [PROD_W-1:0]  px;
  logic signed [PROD_W-1:0]  py;
  logic signed [PROD_W-1:0]  pz;
  logic signed [COORD_W-1:0] off_a;

  // Stage B: signed distance in Q.30
  logic signed [DIST_W-1:0]  distance;
  logic signed [DIST_W-1:0]  distance_next;
  logic signed [DIST_W-1:0]  r_q;

  // Write the slot on a load word that names it
  always_ff @(posedge clk) begin
    if (rst) begin
      nx  <= '0;
      ny  <= '0;
      nz  <= '0;
      off <= '0;
    end else if (ctrl.load && (plane_index == IDX_W'(LANE_IDX))) begin
      nx  <= normal_x;
      ny  <= normal_y;
      nz  <= normal_z;
      off <= plane_offset;
    end
  end

  // Multiply centre by normal, one product per axis
  always_ff @(posedge clk) begin
    if (ctrl.en_a) begin
      px    <= PROD_W'(center_x) * PROD_W'(nx);
      py    <= PROD_W'(center_y) * PROD_W'(ny);
      pz    <= PROD_W'(center_z) * PROD_W'(nz);
      off_a <= off;
    end
  end

  // Sum products and subtract the offset brought to Q.30
  assign distance_next = DIST_W'(px) + DIST_W'(py) + DIST_W'(pz)
                       - (DIST_W'(off_a) <<< FRAC_SHIFT);

  always_ff @(posedge clk) begin
    if (ctrl.en_b) begin
      distance <= distance_next;
    end
  end

  // Compare against the radius in the same format
  assign r_q = $signed({{(DIST_W - RADIUS_W - FRAC_SHIFT){1'b0}}, radius_b,
                        {FRAC_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (ctrl.en_c) begin
      over  <= (r_q < distance);
      under <= (distance < -r_q);
    end
  end

endmodule
